[hdl/tsvt_pkg.sv]
// shared types and constants for the tick-scheduled value table
// no dependencies; used by tsvt_div and tick_scheduled_value_table_core
`timescale 1ns / 1ps

package tsvt_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int VALUE_BITS_DEFAULT = 16;

    localparam int KIND_BITS   = 2;
    localparam int INDEX_BITS  = 6;
    localparam int FIELD_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int MODE_BITS   = 2;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // shared divider: 32-bit numerator, 16-bit denominator, one bit a cycle
    localparam int DIV_NUM_BITS = 32;
    localparam int DIV_DEN_BITS = 16;
    localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_WRITE = 2'd0,
        KIND_RAMP  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_STEP  = 2'd3
    } kind_t;

    localparam logic [MODE_BITS-1:0] END_ZERO = 2'd0;
    localparam logic [MODE_BITS-1:0] END_WRAP = 2'd1;
    localparam logic [MODE_BITS-1:0] END_HOLD = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TICK_DIVIDER = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_END_MODE     = 4'd1;

    typedef struct packed {
        kind_t                          kind;
        logic        [INDEX_BITS-1:0]   entry_index;
        logic signed [FIELD_BITS-1:0]   entry_data;
        logic        [INDEX_BITS-1:0]   ramp_last;
        logic signed [FIELD_BITS-1:0]   ramp_start;
        logic signed [FIELD_BITS-1:0]   ramp_stop;
        logic        [TIME_BITS-1:0]    time_now;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0]   current_value;
        logic                           advanced;
        logic                           finished;
    } rsp_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[hdl/tsvt_ram.sv]
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps

module tsvt_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tsvt_div.sv]
// shared restoring divider, one quotient bit a cycle
// depends on tsvt_pkg
`timescale 1ns / 1ps

module tsvt_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tsvt_pkg::div_ctl_t                 ctl,
    input  logic [tsvt_pkg::DIV_NUM_BITS-1:0]  numer,
    input  logic [tsvt_pkg::DIV_DEN_BITS-1:0]  denom,
    output tsvt_pkg::div_sts_t                 sts,
    output logic [tsvt_pkg::DIV_NUM_BITS-1:0]  quotient,
    output logic [tsvt_pkg::DIV_DEN_BITS-1:0]  remainder
);

    localparam int NB = tsvt_pkg::DIV_NUM_BITS;
    localparam int DB = tsvt_pkg::DIV_DEN_BITS;
    localparam int CB = tsvt_pkg::DIV_CNT_BITS;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [NB-1:0] num_reg, num_next;
    logic [DB-1:0] den_reg, den_next;
    logic [DB-1:0] rem_reg, rem_next;

    logic [DB:0]   trial;
    logic [DB:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NB-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift into the numerator register from the bottom
            num_next = {num_reg[NB-2:0], ge};
            rem_next = ge ? diff[DB-1:0] : trial[DB-1:0];
            cnt_next = cnt_reg + CB'(1);
            if (cnt_reg == CB'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

[hdl/tick_scheduled_value_table_core.sv]
// tick-scheduled value table: setpoint table, playback position and end rule
// depends on tsvt_pkg, tsvt_ram and tsvt_div
//
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  tsvt_pkg::req_t
// rsp      out  rsp_valid / rsp_ready  tsvt_pkg::rsp_t
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// write entry and unconditional advance pass through the exec, end, read and data states per beat
// a timed tick with a non-zero divider also waits on the shared divider
// a ramp with ramp_last above zero waits on the divider, then writes ramp_last + 1 entries, one entry a cycle
// wrap past the end adds another pass on the same divider
// after reset a clearing pass zeroes every table entry while req_ready is low
// a result waits in the output register; the next beat is taken meanwhile
`timescale 1ns / 1ps

module tick_scheduled_value_table_core #(
    parameter int TABLE_DEPTH = tsvt_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS  = tsvt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  tsvt_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output tsvt_pkg::rsp_t                        rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tsvt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tsvt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int IB = tsvt_pkg::INDEX_BITS;
    localparam int FB = tsvt_pkg::FIELD_BITS;
    localparam int NB = tsvt_pkg::DIV_NUM_BITS;
    localparam int DB = tsvt_pkg::DIV_DEN_BITS;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_EXEC  = 10'b0000000100,
        S_RDIV  = 10'b0000001000,
        S_FILL  = 10'b0000010000,
        S_TDIV  = 10'b0000100000,
        S_END   = 10'b0001000000,
        S_WDIV  = 10'b0010000000,
        S_READ  = 10'b0100000000,
        S_DATA  = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          last_reg, last_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [DB-1:0]          tdiv_reg;
    logic [tsvt_pkg::MODE_BITS-1:0] mode_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    tsvt_pkg::req_t         item_reg, item_next;
    tsvt_pkg::rsp_t         rsp_reg, rsp_next;
    logic [IB-1:0]          fill_reg, fill_next;
    logic [FB:0]            acc_q_reg, acc_q_next;
    logic [IB-1:0]          acc_r_reg, acc_r_next;
    logic [FB:0]            q0_reg, q0_next;
    logic [IB-1:0]          r0_reg, r0_next;
    logic                   neg_reg, neg_next;
    logic                   fin_reg, fin_next;
    logic                   adv_reg, adv_next;

    // memory ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_BITS-1:0]  ram_wdata;
    logic                   ram_re;
    logic [VALUE_BITS-1:0]  ram_rdata;

    // shared divider
    tsvt_pkg::div_ctl_t     div_ctl;
    tsvt_pkg::div_sts_t     div_sts;
    logic [NB-1:0]          div_numer;
    logic [DB-1:0]          div_denom;
    logic [NB-1:0]          div_quo;
    logic [DB-1:0]          div_rem;

    logic signed [FB:0]     span;
    logic [FB:0]            span_mag;
    logic signed [FB+1:0]   ramp_off;
    logic signed [FB+1:0]   ramp_sum;
    logic [IB:0]            r_sum;
    logic                   r_carry;
    logic                   idx_ok;
    logic                   rlast_ok;
    logic                   can_bump;
    logic                   fin_now;

    tsvt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(pos_reg)),
        .rdata (ram_rdata)
    );

    tsvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .numer     (div_numer),
        .denom     (div_denom),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        span     = $signed({item_reg.ramp_stop[FB-1], item_reg.ramp_stop})
                 - $signed({item_reg.ramp_start[FB-1], item_reg.ramp_start});
        span_mag = span[FB] ? (FB+1)'(-span) : span;
        ramp_off = neg_reg ? -$signed({1'b0, acc_q_reg}) : $signed({1'b0, acc_q_reg});
        ramp_sum = (FB+2)'($signed(item_reg.ramp_start)) + ramp_off;
        r_sum    = (IB+1)'(acc_r_reg) + (IB+1)'(r0_reg);
        r_carry  = r_sum >= (IB+1)'(item_reg.ramp_last);
        idx_ok   = 32'(item_reg.entry_index) < 32'(TABLE_DEPTH);
        rlast_ok = 32'(item_reg.ramp_last) < 32'(TABLE_DEPTH);
        can_bump = pos_reg < PW'(TABLE_DEPTH);
        fin_now  = 32'(pos_reg) > 32'(last_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        fill_next      = fill_reg;
        acc_q_next     = acc_q_reg;
        acc_r_next     = acc_r_reg;
        q0_next        = q0_reg;
        r0_next        = r0_reg;
        neg_next       = neg_reg;
        fin_next       = fin_reg;
        adv_next       = adv_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        div_ctl.start  = 1'b0;
        div_numer      = NB'(pos_reg);
        div_denom      = DB'(PW'(last_reg) + PW'(1));

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    adv_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_END;
                unique case (item_reg.kind)
                    tsvt_pkg::KIND_WRITE:
                    begin
                        if (idx_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(item_reg.entry_index);
                            ram_wdata = VALUE_BITS'(item_reg.entry_data);
                            if (32'(item_reg.entry_index) > 32'(last_reg))
                            begin
                                last_next = AW'(item_reg.entry_index);
                            end
                        end
                    end
                    tsvt_pkg::KIND_RAMP:
                    begin
                        if (rlast_ok)
                        begin
                            last_next = AW'(item_reg.ramp_last);
                            if (item_reg.ramp_last == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = VALUE_BITS'(item_reg.ramp_start);
                            end
                            else
                            begin
                                // |span| / ramp_last once, then step quotient and remainder
                                div_ctl.start = 1'b1;
                                div_numer     = NB'(span_mag);
                                div_denom     = DB'(item_reg.ramp_last);
                                neg_next      = span[FB];
                                state_next    = S_RDIV;
                            end
                        end
                    end
                    tsvt_pkg::KIND_TICK:
                    begin
                        if (tdiv_reg != '0)
                        begin
                            div_ctl.start = 1'b1;
                            div_numer     = item_reg.time_now;
                            div_denom     = tdiv_reg;
                            state_next    = S_TDIV;
                        end
                    end
                    tsvt_pkg::KIND_STEP:
                    begin
                        if (can_bump)
                        begin
                            pos_next = pos_reg + PW'(1);
                            adv_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end
            S_RDIV:
            begin
                if (div_sts.done)
                begin
                    q0_next    = div_quo[FB:0];
                    r0_next    = div_rem[IB-1:0];
                    acc_q_next = '0;
                    acc_r_next = '0;
                    fill_next  = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(fill_reg);
                ram_wdata = VALUE_BITS'(ramp_sum);
                fill_next = fill_reg + IB'(1);
                // running span * i / ramp_last as quotient plus remainder
                acc_q_next = acc_q_reg + q0_reg + (FB+1)'(r_carry);
                acc_r_next = r_carry ? IB'(r_sum - (IB+1)'(item_reg.ramp_last))
                                     : IB'(r_sum);
                if (fill_reg == item_reg.ramp_last)
                begin
                    state_next = S_END;
                end
            end
            S_TDIV:
            begin
                if (div_sts.done)
                begin
                    if (div_rem == '0 && can_bump)
                    begin
                        pos_next = pos_reg + PW'(1);
                        adv_next = 1'b1;
                    end
                    state_next = S_END;
                end
            end
            S_END:
            begin
                fin_next   = fin_now;
                state_next = S_READ;
                if (fin_now && mode_reg == tsvt_pkg::END_WRAP)
                begin
                    div_ctl.start = 1'b1;
                    state_next    = S_WDIV;
                end
                else if (fin_now && mode_reg == tsvt_pkg::END_HOLD)
                begin
                    pos_next = PW'(last_reg);
                end
            end
            S_WDIV:
            begin
                if (div_sts.done)
                begin
                    pos_next   = PW'(div_rem);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.advanced = adv_reg;
                    rsp_next.finished = fin_reg;
                    if (fin_reg && mode_reg != tsvt_pkg::END_WRAP
                        && mode_reg != tsvt_pkg::END_HOLD)
                    begin
                        rsp_next.current_value = '0;
                    end
                    else
                    begin
                        rsp_next.current_value = FB'($signed(ram_rdata));
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            last_reg      <= '0;
            clr_reg       <= '0;
            tdiv_reg      <= '0;
            mode_reg      <= tsvt_pkg::END_ZERO;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tsvt_pkg::CFG_TICK_DIVIDER)
                begin
                    tdiv_reg <= cfg_data;
                end
                else if (cfg_index == tsvt_pkg::CFG_END_MODE)
                begin
                    mode_reg <= cfg_data[tsvt_pkg::MODE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        rsp_reg   <= rsp_next;
        fill_reg  <= fill_next;
        acc_q_reg <= acc_q_next;
        acc_r_reg <= acc_r_next;
        q0_reg    <= q0_next;
        r0_reg    <= r0_next;
        neg_reg   <= neg_next;
        fin_reg   <= fin_next;
        adv_reg   <= adv_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTH
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= 32'(TABLE_DEPTH))
        else $error("position beyond table depth");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider restarted while busy");

    a_rsp_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DATA)
        else $error("result raised outside the data state");

    // only wrap and hold use an entry read past the end, both move the position back first
    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> 32'(pos_reg) < 32'(TABLE_DEPTH) || !fin_reg
            || (mode_reg != tsvt_pkg::END_WRAP && mode_reg != tsvt_pkg::END_HOLD))
        else $error("table read past its last entry");
`endif

endmodule

[dv/tb_top.sv]
// testbench for tick_scheduled_value_table_core: directed beats, a stall test and random phases,
// each result checked against an in-bench model of the table, position and end rule
// depends on tsvt_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;

    import tsvt_pkg::*;

    localparam int TABLE_SIZE      = 64;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 160;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_COUNT     = 10;
    localparam int PHASE_BEATS     = 100;
    localparam logic [MODE_BITS-1:0] END_SPARE = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_ready;
    req_t                       req;
    logic                       rsp_valid;
    logic                       rsp_ready;
    rsp_t                       rsp;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    tick_scheduled_value_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic signed [FIELD_BITS-1:0]   setpoints [TABLE_SIZE];
    logic [6:0]                     play_pos;
    logic [INDEX_BITS-1:0]          end_idx;
    logic [CFG_DATA_BITS-1:0]       divider_cfg;
    logic [MODE_BITS-1:0]           mode_cfg;

    rsp_t expected_values [$];
    int   failures         = 0;
    int   req_gap_max      = 4;
    int   rsp_stall_max    = 4;
    int   rsp_hold_request = 0;

    always #10 clk = ~clk;

    function automatic void reset_model();
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            setpoints[i] = '0;
        end
        play_pos    = '0;
        end_idx     = '0;
        divider_cfg = '0;
        mode_cfg    = END_ZERO;
    endfunction

    function automatic logic bump_position();
        if (play_pos < TABLE_SIZE)
        begin
            play_pos = play_pos + 7'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic rsp_t predict_playback(req_t item);
        rsp_t   outcome;
        longint first;
        longint span;
        longint count;
        outcome = '0;
        case (item.kind)
            KIND_WRITE:
            begin
                setpoints[item.entry_index] = item.entry_data;
                if (item.entry_index > end_idx)
                    end_idx = item.entry_index;
            end
            KIND_RAMP:
            begin
                end_idx = item.ramp_last;
                first   = longint'($signed(item.ramp_start));
                span    = longint'($signed(item.ramp_stop)) - first;
                count   = longint'(item.ramp_last);
                if (count == 0)
                    setpoints[0] = item.ramp_start;
                else
                    for (int i = 0; i <= count; i++)
                    begin
                        setpoints[i] = FIELD_BITS'(first + span * i / count);
                    end
            end
            KIND_TICK:
            begin
                if (divider_cfg != 0 && (item.time_now % divider_cfg) == 0)
                    outcome.advanced = bump_position();
            end
            KIND_STEP:
            begin
                outcome.advanced = bump_position();
            end
        endcase
        outcome.finished = play_pos > end_idx;
        if (!outcome.finished)
            outcome.current_value = setpoints[play_pos];
        else if (mode_cfg == END_WRAP)
        begin
            play_pos = play_pos % (end_idx + 7'd1);
            outcome.current_value = setpoints[play_pos];
        end
        else if (mode_cfg == END_HOLD)
        begin
            play_pos = 7'(end_idx);
            outcome.current_value = setpoints[play_pos];
        end
        // zero output and the spare mode both leave the value at zero
        return outcome;
    endfunction

    function automatic void report_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic void check_result(rsp_t got);
        rsp_t want;
        if (expected_values.size() == 0)
        begin
            report_failure($sformatf("unexpected result: value %0d advanced %0b finished %0b",
                                     got.current_value, got.advanced, got.finished));
            return;
        end
        want = expected_values.pop_front();
        if (got.current_value !== want.current_value || got.advanced !== want.advanced ||
            got.finished !== want.finished)
            report_failure($sformatf({"mismatch: expected value %0d advanced %0b finished %0b,",
                                      " got value %0d advanced %0b finished %0b"},
                                     want.current_value, want.advanced, want.finished,
                                     got.current_value, got.advanced, got.finished));
    endfunction

    function automatic req_t noise_item(kind_t k);
        req_t item;
        item.kind        = k;
        item.entry_index = INDEX_BITS'($urandom);
        item.entry_data  = FIELD_BITS'($urandom);
        item.ramp_last   = INDEX_BITS'($urandom);
        item.ramp_start  = FIELD_BITS'($urandom);
        item.ramp_stop   = FIELD_BITS'($urandom);
        item.time_now    = TIME_BITS'($urandom);
        return item;
    endfunction

    function automatic req_t random_item();
        req_t        item;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 30)
            item = noise_item(KIND_WRITE);
        else if (pick < 40)
            item = noise_item(KIND_RAMP);
        else if (pick < 72)
            item = noise_item(KIND_TICK);
        else
            item = noise_item(KIND_STEP);
        case (item.kind)
            KIND_WRITE:
            begin
                if ($urandom_range(1, 0))
                    item.entry_index = INDEX_BITS'($urandom_range(7, 0));
            end
            KIND_RAMP:
            begin
                // keep most ramps short, the fill writes each entry of the ramp in turn
                if ($urandom_range(3, 0) != 0)
                    item.ramp_last = INDEX_BITS'($urandom_range(15, 0));
            end
            KIND_TICK:
            begin
                if (divider_cfg != 0 && $urandom_range(1, 0))
                    item.time_now = TIME_BITS'(divider_cfg
                                    * $urandom_range(32'hFFFF_FFFF / divider_cfg, 0));
            end
            default:
            begin
            end
        endcase
        return item;
    endfunction

    // one beat on the request channel; valid stays up when the next beat follows at once
    task automatic send_req(input req_t item);
        int gap;
        gap = $urandom_range(req_gap_max, 0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        expected_values.push_back(predict_playback(item));
    endtask

    task automatic send_write(input logic [INDEX_BITS-1:0] idx, input logic [FIELD_BITS-1:0] data);
        req_t item;
        item             = noise_item(KIND_WRITE);
        item.entry_index = idx;
        item.entry_data  = data;
        send_req(item);
    endtask

    task automatic send_ramp(input logic [INDEX_BITS-1:0] last, input logic [FIELD_BITS-1:0] first,
                             input logic [FIELD_BITS-1:0] stop);
        req_t item;
        item            = noise_item(KIND_RAMP);
        item.ramp_last  = last;
        item.ramp_start = first;
        item.ramp_stop  = stop;
        send_req(item);
    endtask

    task automatic send_tick(input logic [TIME_BITS-1:0] stamp);
        req_t item;
        item          = noise_item(KIND_TICK);
        item.time_now = stamp;
        send_req(item);
    endtask

    task automatic send_step();
        send_req(noise_item(KIND_STEP));
    endtask

    // registers change only with the block drained and settled
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        req_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TICK_DIVIDER)
            divider_cfg = value;
        else if (idx == CFG_END_MODE)
            mode_cfg = value[MODE_BITS-1:0];
    endtask

    task automatic test_entry_writes();
        write_reg(CFG_END_MODE, CFG_DATA_BITS'(END_ZERO));
        write_reg(CFG_TICK_DIVIDER, 16'd0);
        send_write(6'd0, 16'h8000);
        send_write(6'd63, 16'h7FFF);
        send_write(6'd1, 16'h5555);
        send_write(6'd2, 16'hAAAA);
    endtask

    task automatic test_ramp_fill();
        write_reg(CFG_END_MODE, CFG_DATA_BITS'(END_HOLD));
        send_ramp(6'd63, 16'h8000, 16'h7FFF);
        send_ramp(6'd63, 16'h7FFF, 16'h8000);
        // negative span that does not divide evenly, truncation toward zero
        send_ramp(6'd7, 16'd0, 16'hFFF6);
        send_ramp(6'd1, 16'd100, 16'hFF9C);
        send_ramp(6'd0, 16'd1234, 16'h7FFF);
    endtask

    task automatic test_timed_ticks();
        write_reg(CFG_END_MODE, CFG_DATA_BITS'(END_WRAP));
        write_reg(CFG_TICK_DIVIDER, 16'd0);
        send_ramp(6'd3, 16'd10, 16'd40);
        send_tick(32'd0);
        write_reg(CFG_TICK_DIVIDER, 16'd1);
        send_tick(32'd12345);
        send_tick(32'hFFFF_FFFF);
        write_reg(CFG_TICK_DIVIDER, 16'hFFFF);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd65534);
        send_tick(32'd0);
    endtask

    task automatic test_end_modes();
        logic [MODE_BITS-1:0] modes [4] = '{END_ZERO, END_WRAP, END_HOLD, END_SPARE};
        foreach (modes[m])
        begin
            write_reg(CFG_END_MODE, CFG_DATA_BITS'(modes[m]));
            send_ramp(6'd1, 16'hFFFB, 16'd5);
            send_step();
            send_step();
        end
    endtask

    task automatic test_saturation();
        write_reg(CFG_END_MODE, CFG_DATA_BITS'(END_ZERO));
        repeat (70) send_step();
    endtask

    task automatic test_backpressure();
        req_gap_max      = 0;
        rsp_stall_max    = 0;
        rsp_hold_request = RSP_HOLD_CYCLES;
        repeat (24) send_req(random_item());
        req_gap_max   = 4;
        rsp_stall_max = 4;
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_BITS-1:0] divider;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 0)
                divider = '0;
            else if (phase == 1)
                divider = '1;
            else if ($urandom_range(1, 0))
                divider = CFG_DATA_BITS'($urandom_range(8, 1));
            else
                divider = CFG_DATA_BITS'($urandom);
            write_reg(CFG_TICK_DIVIDER, divider);
            write_reg(CFG_END_MODE, CFG_DATA_BITS'($urandom_range(END_SPARE, END_ZERO)));
            req_gap_max   = (phase % 2 == 1) ? 0 : 4;
            rsp_stall_max = (phase % 3 == 1) ? 0 : 4;
            repeat (PHASE_BEATS) send_req(random_item());
        end
    endtask

    initial
    begin : result_checker
        int stall;
        stall     = 0;
        rsp_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                check_result(rsp);
                if (rsp_hold_request > 0)
                begin
                    stall            = rsp_hold_request;
                    rsp_hold_request = 0;
                end
                else
                    stall = $urandom_range(rsp_stall_max, 0);
                if (stall > 0)
                    rsp_ready <= 1'b0;
            end
            else if (!rsp_ready)
            begin
                stall--;
                if (stall <= 0)
                    rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_entry_writes();
        test_ramp_fill();
        test_timed_ticks();
        test_end_modes();
        test_saturation();
        test_backpressure();
        test_random_phases();

        req_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
